FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; taken in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ald_pkg.sv
// shared constants, types and helper functions of the least loaded dispatcher
// no dependencies; used by every module of the block but ald_ram, by scoped names
`timescale 1ns / 1ps

package ald_pkg;

  localparam int MAX_CORES   = 32;
  localparam int CORE_W      = $clog2(MAX_CORES);
  localparam int GRP_SIZE    = 8;
  localparam int NUM_GRP     = MAX_CORES / GRP_SIZE;
  localparam int USER_SLOTS  = 4096;
  localparam int SLOT_W      = $clog2(USER_SLOTS);
  localparam int UID_W       = 12;
  localparam int RUN_W       = 16;
  localparam int LOAD_W      = 32;
  localparam int NC_W        = 6;
  localparam int BIND_W      = CORE_W + 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CORES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(1);

  localparam logic [NC_W-1:0]   NUM_CORES_RST = NC_W'(1);
  localparam logic [LOAD_W-1:0] LOAD_MAX      = {LOAD_W{1'b1}};

  // one classified job on its way from the front to the back
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [RUN_W-1:0]  run;
    logic [LOAD_W-1:0] thr;
    logic              none_ok;
    logic              bound;
    logic [CORE_W-1:0] bcore;
  } job_t;

  // binding store write issued by the back
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CORE_W-1:0] core;
  } bind_wr_t;

  // candidate core in the minimum search
  typedef struct packed {
    logic              found;
    logic [CORE_W-1:0] idx;
    logic [LOAD_W-1:0] val;
  } cand_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SRCH,
    B_CMT
  } back_state_t;

  // a job read before a binding for its slot was written picks that binding up
  function automatic job_t snoop(job_t j, bind_wr_t w);
    job_t r;
    r = j;
    if (w.en && (w.slot == j.slot) && !j.bound) begin
      r.bound = 1'b1;
      r.bcore = w.core;
    end
    return r;
  endfunction

  // a holds the lower indices, so it wins ties
  function automatic cand_t pick(cand_t a, cand_t b);
    cand_t r;
    if (a.found && (!b.found || (a.val <= b.val))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ald_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ald_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ald_front.sv
// front of the dispatcher: input beat acceptance, binding store and its clearing pass,
// classification of each job. depends on ald_pkg and ald_ram
`timescale 1ns / 1ps

module ald_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // user_id[11:0], run_time[27:12], deadline[59:28], zero fill
  input  logic [ald_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [ald_pkg::LOAD_W-1:0]        capacity,
  input  logic [ald_pkg::QCNT_W-1:0]        q_level,
  input  ald_pkg::bind_wr_t                 bwr,
  output logic                              push,
  output ald_pkg::job_t                     push_job,
  output logic                              clearing
);

  logic                          accept;
  logic [ald_pkg::UID_W-1:0]     uid;
  logic [ald_pkg::RUN_W-1:0]     run;
  logic [ald_pkg::LOAD_W-1:0]    dl;
  logic [ald_pkg::LOAD_W-1:0]    limit;
  logic                          none_ok;
  logic [ald_pkg::LOAD_W-1:0]    thr;

  logic                          we;
  logic [ald_pkg::SLOT_W-1:0]    waddr;
  logic [ald_pkg::BIND_W-1:0]    wdata;
  logic [ald_pkg::BIND_W-1:0]    rdata;

  logic                          f_valid;
  logic [ald_pkg::SLOT_W-1:0]    f_slot;
  logic [ald_pkg::RUN_W-1:0]     f_run;
  logic [ald_pkg::LOAD_W-1:0]    f_thr;
  logic                          f_none_ok;
  ald_pkg::bind_wr_t             wq;
  logic [ald_pkg::SLOT_W-1:0]    clr_addr;
  ald_pkg::job_t                 raw;

  assign uid = s_axis_tdata[ald_pkg::UID_W-1:0];
  assign run = s_axis_tdata[ald_pkg::UID_W +: ald_pkg::RUN_W];
  assign dl  = s_axis_tdata[ald_pkg::UID_W + ald_pkg::RUN_W +: ald_pkg::LOAD_W];

  assign s_axis_tready = !clearing &&
    ((ald_pkg::QCNT_W'(f_valid) + q_level) < ald_pkg::QCNT_W'(ald_pkg::QDEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  // fit test reduced to load <= min(deadline, capacity) - run_time
  assign limit   = (dl < capacity) ? dl : capacity;
  assign none_ok = limit < {{(ald_pkg::LOAD_W - ald_pkg::RUN_W){1'b0}}, run};
  assign thr     = limit - {{(ald_pkg::LOAD_W - ald_pkg::RUN_W){1'b0}}, run};

  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = bwr.en;
      waddr = bwr.slot;
      wdata = {1'b1, bwr.core};
    end
  end

  ald_ram #(
    .WIDTH (ald_pkg::BIND_W),
    .DEPTH (ald_pkg::USER_SLOTS)
  ) u_bind_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (uid[ald_pkg::SLOT_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ald_pkg::SLOT_W'(1);
      if (clr_addr == ald_pkg::SLOT_W'(ald_pkg::USER_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      wq      <= '0;
    end else begin
      f_valid <= accept;
      wq      <= bwr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_slot    <= uid[ald_pkg::SLOT_W-1:0];
      f_run     <= run;
      f_thr     <= thr;
      f_none_ok <= none_ok;
    end
  end

  // writes in the read cycle and in the data cycle are missed by the ram read
  always_comb begin
    raw.slot    = f_slot;
    raw.run     = f_run;
    raw.thr     = f_thr;
    raw.none_ok = f_none_ok;
    raw.bound   = rdata[ald_pkg::BIND_W-1];
    raw.bcore   = rdata[ald_pkg::CORE_W-1:0];
    push_job    = ald_pkg::snoop(ald_pkg::snoop(raw, wq), bwr);
  end

  assign push = f_valid;

endmodule

FILE: hw/rtl/ald_queue.sv
// short job queue between front and back; queued jobs pick up new bindings
// depends on ald_pkg
`timescale 1ns / 1ps

module ald_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  ald_pkg::job_t              push_job,
  input  logic                       pop,
  input  ald_pkg::bind_wr_t          bwr,
  output logic                       head_valid,
  output ald_pkg::job_t              head,
  output logic [ald_pkg::QCNT_W-1:0] level
);

  ald_pkg::job_t              mem [ald_pkg::QDEPTH];
  logic [ald_pkg::QPTR_W-1:0] rd_ptr;
  logic [ald_pkg::QPTR_W-1:0] wr_ptr;
  logic                       do_pop;

  assign head_valid = level != '0;
  assign head       = ald_pkg::snoop(mem[rd_ptr], bwr);
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ald_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ald_pkg::QPTR_W'(1);
      end
      level <= level + ald_pkg::QCNT_W'(push) - ald_pkg::QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ald_pkg::QDEPTH; i++) begin
      if (push && (wr_ptr == ald_pkg::QPTR_W'(i))) begin
        mem[i] <= push_job;
      end else begin
        mem[i] <= ald_pkg::snoop(mem[i], bwr);
      end
    end
  end

endmodule

FILE: hw/rtl/ald_back.sv
// back of the dispatcher: two step least load search, core load update,
// binding write and output register. depends on ald_pkg
`timescale 1ns / 1ps

module ald_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ald_pkg::NC_W-1:0]          num_cores,
  input  logic                              q_valid,
  input  ald_pkg::job_t                     q_head,
  output logic                              q_pop,
  output ald_pkg::bind_wr_t                 bwr,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // core[4:0], new_binding[5], fits[6], load_after[38:7], zero fill
  output logic [ald_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  ald_pkg::back_state_t       state;
  ald_pkg::back_state_t       state_next;
  ald_pkg::job_t              b_job;
  ald_pkg::cand_t             grp [ald_pkg::NUM_GRP];
  ald_pkg::cand_t             grp_next [ald_pkg::NUM_GRP];
  ald_pkg::cand_t             best;
  logic [ald_pkg::LOAD_W-1:0] core_load [ald_pkg::MAX_CORES];
  logic                       commit;
  logic [ald_pkg::CORE_W-1:0] chosen;
  logic                       fit;
  logic [ald_pkg::LOAD_W:0]   sum;
  logic [ald_pkg::LOAD_W-1:0] load_new;

  always_comb begin
    state_next = state;
    case (state)
      ald_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = ald_pkg::B_SRCH;
        end
      end
      ald_pkg::B_SRCH: begin
        state_next = ald_pkg::B_CMT;
      end
      ald_pkg::B_CMT: begin
        if (commit) begin
          state_next = q_valid ? ald_pkg::B_SRCH : ald_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ald_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    commit   = (state == ald_pkg::B_CMT) && (!m_axis_tvalid || m_axis_tready);
    q_pop    = q_valid && ((state == ald_pkg::B_IDLE) || commit);
    bwr.en   = commit && !b_job.bound;
    bwr.slot = b_job.slot;
    bwr.core = chosen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ald_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_job <= q_head;
    end
  end

  // first step: per group minimum over eight cores
  always_comb begin : search
    ald_pkg::cand_t         lv [ald_pkg::GRP_SIZE];
    logic [ald_pkg::NC_W-1:0] active;
    int                     k;
    active = (num_cores > ald_pkg::NC_W'(ald_pkg::MAX_CORES)) ?
             ald_pkg::NC_W'(ald_pkg::MAX_CORES) : num_cores;
    for (int g = 0; g < ald_pkg::NUM_GRP; g++) begin
      for (int i = 0; i < ald_pkg::GRP_SIZE; i++) begin
        k           = g * ald_pkg::GRP_SIZE + i;
        lv[i].found = (ald_pkg::NC_W'(k) < active) && !b_job.none_ok &&
                      (core_load[k] <= b_job.thr);
        lv[i].idx   = ald_pkg::CORE_W'(k);
        lv[i].val   = core_load[k];
      end
      for (int s = ald_pkg::GRP_SIZE / 2; s >= 1; s = s >> 1) begin
        for (int i = 0; i < s; i++) begin
          lv[i] = ald_pkg::pick(lv[2 * i], lv[2 * i + 1]);
        end
      end
      grp_next[g] = lv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ald_pkg::B_SRCH) begin
      grp <= grp_next;
    end
  end

  // second step: pick among the groups, then update the chosen core
  always_comb begin : finish
    ald_pkg::cand_t lg [ald_pkg::NUM_GRP];
    for (int g = 0; g < ald_pkg::NUM_GRP; g++) begin
      lg[g] = grp[g];
    end
    for (int s = ald_pkg::NUM_GRP / 2; s >= 1; s = s >> 1) begin
      for (int i = 0; i < s; i++) begin
        lg[i] = ald_pkg::pick(lg[2 * i], lg[2 * i + 1]);
      end
    end
    best     = lg[0];
    fit      = !b_job.bound && best.found;
    if (b_job.bound) begin
      chosen = b_job.bcore;
    end else if (best.found) begin
      chosen = best.idx;
    end else begin
      chosen = '0;
    end
    sum      = {1'b0, core_load[chosen]} +
               {{(ald_pkg::LOAD_W + 1 - ald_pkg::RUN_W){1'b0}}, b_job.run};
    load_new = sum[ald_pkg::LOAD_W] ? ald_pkg::LOAD_MAX : sum[ald_pkg::LOAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ald_pkg::MAX_CORES; i++) begin
        core_load[i] <= '0;
      end
    end else if (commit) begin
      core_load[chosen] <= load_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {1'b0, load_new, fit, !b_job.bound, chosen};
    end
  end

endmodule

FILE: hw/rtl/affinity_least_loaded_dispatch_top.sv
// Least loaded core dispatcher with user affinity. Each input beat is one job; each job
// gives one output beat with the core it went to and that core's new load. A user already
// bound keeps its core; an unbound user gets the active core with the smallest load that
// still meets deadline and capacity, lowest index on ties, core 0 if none fits. After reset
// the binding memory is cleared in a pass over all 4096 slots during which no job is taken;
// configuration writes are taken at any time. The two step minimum search over the 32 core
// loads must finish and update a load before the next job's search starts, so the searches
// of two jobs never overlap. A job passes the front register, the queue, the group minimum
// register and the output register on its way to its output beat.
// depends on ald_pkg, ald_front, ald_queue, ald_back and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module affinity_least_loaded_dispatch_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // user_id[11:0], run_time[27:12], deadline[59:28], zero fill
  input  logic [ald_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // core[4:0], new_binding[5], fits[6], load_after[38:7], zero fill
  output logic [ald_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ald_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ald_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [ald_pkg::NC_W-1:0]   num_cores;
  logic [ald_pkg::LOAD_W-1:0] capacity;
  logic                       clearing;
  logic                       push;
  ald_pkg::job_t              push_job;
  logic                       q_pop;
  logic                       q_valid;
  ald_pkg::job_t              q_head;
  logic [ald_pkg::QCNT_W-1:0] q_level;
  ald_pkg::bind_wr_t          bwr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cores <= ald_pkg::NUM_CORES_RST;
      capacity  <= ald_pkg::LOAD_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ald_pkg::REG_NUM_CORES: num_cores <= cfg_data[ald_pkg::NC_W-1:0];
        ald_pkg::REG_CAPACITY:  capacity  <= cfg_data[ald_pkg::LOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ald_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .capacity      (capacity),
    .q_level       (q_level),
    .bwr           (bwr),
    .push          (push),
    .push_job      (push_job),
    .clearing      (clearing)
  );

  ald_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (q_pop),
    .bwr        (bwr),
    .head_valid (q_valid),
    .head       (q_head),
    .level      (q_level)
  );

  ald_back u_back (
    .clk           (clk),
    .rst           (rst),
    .num_cores     (num_cores),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .bwr           (bwr),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // no job is taken while the binding memory is being cleared
  `ASSERT_IMPLIES(a_no_accept_clearing, clk, rst, s_axis_tready, !clearing, "job taken during clear")
  `ASSERT_IMPLIES(a_no_bind_clearing, clk, rst, bwr.en, !clearing, "binding write during clear")
  // a new binding is always reported on the next cycle
  `ASSERT_NEXT(a_bind_reported, clk, rst, bwr.en, m_axis_tvalid, "binding without output beat")
  `ASSERT_HOLDS(a_queue_bound, clk, rst, q_level <= ald_pkg::QCNT_W'(ald_pkg::QDEPTH), "queue overrun")

endmodule
